>>> rtl/core/pcd_pkg.sv
// Shared constants and types of the prefix code table decoder.
`default_nettype none
package pcd_pkg;
	localparam int TABLE_SLOTS   = 256;
	localparam int MAX_CODE_BITS = 32;
	localparam int BYTE_BITS     = 8;

	localparam int SLOT_IDX_W = 8;
	localparam int SYM_W      = 8;
	localparam int LEN_W      = 6;
	localparam int CODE_W     = 32;
	localparam int FUNC_W     = 2;
	localparam int COUNT_W    = 32;

	localparam int GROUP_SIZE = 16;
	localparam int NUM_GROUPS = (TABLE_SLOTS + GROUP_SIZE - 1) / GROUP_SIZE;

	localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_DATA    = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;

	typedef struct packed {
		logic                  en;
		logic [SLOT_IDX_W-1:0] index;
		logic [SYM_W-1:0]      symbol;
		logic [LEN_W-1:0]      length;
		logic [CODE_W-1:0]     code;
	} slot_load_t;

	typedef struct packed {
		logic [CODE_W-1:0] acc;
		logic [CODE_W-1:0] mask;
		logic [LEN_W-1:0]  len;
	} probe_t;
endpackage
`default_nettype wire

>>> rtl/core/pcd_cell.sv
// One table slot: storage, code compare and a link of the priority chain.
`default_nettype none
module pcd_cell (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                load_en,
	input  wire pcd_pkg::slot_load_t load,
	input  wire pcd_pkg::probe_t     probe,
	input  wire logic                taken_in,
	input  wire logic [7:0]          sym_in,
	output logic                     taken_out,
	output logic [7:0]               sym_out
);
	import pcd_pkg::*;

	logic [SYM_W-1:0]  symbol_q;
	logic [LEN_W-1:0]  length_q;
	logic [CODE_W-1:0] code_q;
	logic              hit_q;
	logic              hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= '0;
		end else if (load_en) begin
			length_q <= load.length;
		end
	end

	always_ff @(posedge clk) begin
		if (load_en) begin
			symbol_q <= load.symbol;
			code_q   <= load.code;
		end
	end

	assign hit = (length_q != '0) && (length_q == probe.len) &&
		(((code_q ^ probe.acc) & probe.mask) == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else begin
			hit_q <= hit;
		end
	end

	// A lower slot that already matched keeps its symbol.
	assign taken_out = taken_in | hit_q;
	assign sym_out   = (!taken_in && hit_q) ? symbol_q : sym_in;
endmodule
`default_nettype wire

>>> rtl/core/pcd_row.sv
// The row of slot cells, grouped, with registered group results and the final pick.
`default_nettype none
module pcd_row (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire pcd_pkg::slot_load_t load,
	input  wire pcd_pkg::probe_t     probe,
	output logic                     match,
	output logic [7:0]               match_symbol
);
	import pcd_pkg::*;

	logic [NUM_GROUPS-1:0] grp_hit_q;
	logic [SYM_W-1:0]      grp_sym_q [NUM_GROUPS];

	for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_group
		logic [GROUP_SIZE:0] tk;
		logic [SYM_W-1:0]    sy [GROUP_SIZE+1];

		assign tk[0] = 1'b0;
		assign sy[0] = '0;

		for (genvar k = 0; k < GROUP_SIZE; k++) begin : g_slot
			localparam int SLOT = g * GROUP_SIZE + k;
			if (SLOT < TABLE_SLOTS) begin : g_cell
				logic load_en;
				assign load_en = load.en && (load.index == SLOT_IDX_W'(SLOT));
				pcd_cell u_cell (
					.clk       (clk),
					.arst_n    (arst_n),
					.load_en   (load_en),
					.load      (load),
					.probe     (probe),
					.taken_in  (tk[k]),
					.sym_in    (sy[k]),
					.taken_out (tk[k+1]),
					.sym_out   (sy[k+1])
				);
			end else begin : g_empty
				assign tk[k+1] = tk[k];
				assign sy[k+1] = sy[k];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				grp_hit_q[g] <= 1'b0;
			end else begin
				grp_hit_q[g] <= tk[GROUP_SIZE];
			end
		end

		always_ff @(posedge clk) begin
			grp_sym_q[g] <= sy[GROUP_SIZE];
		end
	end

	// Lowest group with a hit wins.
	always_comb begin
		match        = 1'b0;
		match_symbol = '0;
		for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
			if (grp_hit_q[g]) begin
				match        = 1'b1;
				match_symbol = grp_sym_q[g];
			end
		end
	end
endmodule
`default_nettype wire

>>> rtl/core/prefix_code_table_decoder_top.sv
// Top level of the prefix code table decoder: control, accumulator and result register.
//
// Usage. Input transactions arrive on item_valid/item_stall with func selecting a
// table load, a data byte or a stream restart. A load or a restart gives no result.
// A data byte is examined one stream bit at a time; each bit goes through the steps
// shift into the accumulator, compare in every slot cell, register the group
// results, and resolve and update. item_stall stays high until the block is through
// with the byte, so no new transaction is taken before that. Once the expected count
// is reached the remaining bits are skipped, so a byte may be dropped whole. Result
// transactions leave on result_valid/result_stall, at most eight per data byte; the
// last one of a byte carries last_of_run. A result is held back until the next one
// appears or the byte ends, so that last_of_run is known when it is offered. The
// result register decouples the two sides: a stalled result holds, the decoder keeps
// working until it has a second result ready, and then waits. The user writes the
// expected symbol count (expected_q) through cfg_we/cfg_wdata only while the block
// is idle; the block itself does not enforce this. Reset clears the accumulator,
// the symbol count, the register and every slot length, so all slots start invalid.
`default_nettype none
module prefix_code_table_decoder_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [pcd_pkg::COUNT_W-1:0] cfg_wdata,
	input  wire logic                        item_valid,
	output logic                             item_stall,
	input  wire logic [pcd_pkg::FUNC_W-1:0]  func,
	input  wire logic [7:0]                  entry_index,
	input  wire logic [7:0]                  entry_symbol,
	input  wire logic [5:0]                  entry_length,
	input  wire logic [31:0]                 entry_code,
	input  wire logic [7:0]                  data_byte,
	output logic                             result_valid,
	input  wire logic                        result_stall,
	output logic [7:0]                       symbol,
	output logic                             no_match,
	output logic                             stream_done,
	output logic                             last_of_run
);
	import pcd_pkg::*;

	localparam int BIT_CNT_W = $clog2(BYTE_BITS + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SHIFT = 3'd1;
	localparam logic [2:0] ST_CMP   = 3'd2;
	localparam logic [2:0] ST_GRP   = 3'd3;
	localparam logic [2:0] ST_FIN   = 3'd4;
	localparam logic [2:0] ST_FLUSH = 3'd5;

	logic [2:0]           state_q;
	logic [COUNT_W-1:0]   expected_q;
	logic [COUNT_W-1:0]   decoded_q;
	logic [CODE_W-1:0]    acc_q;
	logic [LEN_W-1:0]     len_q;
	logic [BYTE_BITS-1:0] byte_q;
	logic [BIT_CNT_W-1:0] bit_cnt_q;

	// Pending result, held until it is known whether it ends the byte.
	logic             pend_valid_q;
	logic [SYM_W-1:0] pend_symbol_q;
	logic             pend_no_match_q;
	logic             pend_done_q;

	logic             accept;
	logic             out_free;
	logic             match;
	logic [SYM_W-1:0] match_symbol;
	logic             overflow;
	logic             have_res;
	logic             fin_go;
	logic             push_mid;
	logic             push_last;
	logic             stream_full;
	slot_load_t       load;
	probe_t           probe;

	assign item_stall  = (state_q != ST_IDLE);
	assign accept      = item_valid && !item_stall;
	assign out_free    = !result_valid || !result_stall;
	assign stream_full = (decoded_q >= expected_q);

	assign load.en     = accept && (func == FUNC_LOAD);
	assign load.index  = entry_index;
	assign load.symbol = entry_symbol;
	assign load.length = entry_length;
	assign load.code   = entry_code;

	// Only the accumulated bits take part in the compare.
	always_comb begin
		probe.acc = acc_q;
		probe.len = len_q;
		for (int i = 0; i < CODE_W; i++) begin
			probe.mask[i] = (LEN_W'(i) < len_q);
		end
	end

	pcd_row u_row (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (load),
		.probe        (probe),
		.match        (match),
		.match_symbol (match_symbol)
	);

	assign overflow = !match && (len_q >= LEN_W'(MAX_CODE_BITS));
	assign have_res = match || overflow;
	// A new result can be taken unless the pending one cannot leave.
	assign fin_go    = (state_q == ST_FIN) && (!have_res || !pend_valid_q || out_free);
	assign push_mid  = fin_go && have_res && pend_valid_q;
	assign push_last = (state_q == ST_FLUSH) && pend_valid_q && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q <= '0;
		end else if (cfg_we) begin
			expected_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			decoded_q    <= '0;
			acc_q        <= '0;
			len_q        <= '0;
			bit_cnt_q    <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && func == FUNC_RESTART) begin
						acc_q     <= '0;
						len_q     <= '0;
						decoded_q <= '0;
					end else if (accept && func == FUNC_DATA) begin
						bit_cnt_q <= '0;
						state_q   <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					if (bit_cnt_q == BIT_CNT_W'(BYTE_BITS) || stream_full) begin
						state_q <= ST_FLUSH;
					end else begin
						acc_q   <= {acc_q[CODE_W-2:0], byte_q[BYTE_BITS-1]};
						len_q   <= len_q + LEN_W'(1);
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					state_q <= ST_GRP;
				end
				ST_GRP: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_go) begin
						if (have_res) begin
							pend_valid_q <= 1'b1;
							acc_q        <= '0;
							len_q        <= '0;
						end
						if (match) begin
							decoded_q <= decoded_q + COUNT_W'(1);
						end
						bit_cnt_q <= bit_cnt_q + BIT_CNT_W'(1);
						state_q   <= ST_SHIFT;
					end
				end
				ST_FLUSH: begin
					if (!pend_valid_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && func == FUNC_DATA) begin
			byte_q <= data_byte;
		end else if (state_q == ST_SHIFT && bit_cnt_q != BIT_CNT_W'(BYTE_BITS)) begin
			byte_q <= {byte_q[BYTE_BITS-2:0], 1'b0};
		end
		if (fin_go && have_res) begin
			pend_symbol_q   <= match ? match_symbol : '0;
			pend_no_match_q <= !match;
			pend_done_q     <= match && ((decoded_q + COUNT_W'(1)) == expected_q);
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (push_mid || push_last) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_mid || push_last) begin
			symbol      <= pend_symbol_q;
			no_match    <= pend_no_match_q;
			stream_done <= pend_done_q;
			last_of_run <= push_last;
		end
	end
endmodule
`default_nettype wire

>>> tb/pcd_decode_checker.sv
// Checker for the prefix code table decoder: predicts each decoded symbol and compares results.
module pcd_decode_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [pcd_pkg::COUNT_W-1:0]      cfg_wdata,
	input  logic                             item_valid,
	input  logic                             item_stall,
	input  logic [pcd_pkg::FUNC_W-1:0]       func,
	input  logic [pcd_pkg::SLOT_IDX_W-1:0]   entry_index,
	input  logic [pcd_pkg::SYM_W-1:0]        entry_symbol,
	input  logic [pcd_pkg::LEN_W-1:0]        entry_length,
	input  logic [pcd_pkg::CODE_W-1:0]       entry_code,
	input  logic [7:0]                       data_byte,
	input  logic                             result_valid,
	input  logic                             result_stall,
	input  logic [pcd_pkg::SYM_W-1:0]        symbol,
	input  logic                             no_match,
	input  logic                             stream_done,
	input  logic                             last_of_run,
	output int                               mismatches,
	output int                               outstanding,
	output int                               symbols_checked,
	output int                               misses_checked
);
	timeunit 1ns;
	timeprecision 1ps;
	import pcd_pkg::*;

	localparam int REPORT_LIMIT = 100;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             no_match;
		logic             stream_done;
		logic             last_of_run;
	} decoded_t;

	logic [SYM_W-1:0]   slot_sym  [TABLE_SLOTS];
	logic [LEN_W-1:0]   slot_len  [TABLE_SLOTS];
	logic [CODE_W-1:0]  slot_code [TABLE_SLOTS];
	logic [CODE_W-1:0]  acc;
	int unsigned        acc_len;
	logic [COUNT_W-1:0] decoded;
	logic [COUNT_W-1:0] target;
	decoded_t           awaited_symbols[$];

	// Walks the byte bit by bit, MSB first, and queues every symbol or miss it produces.
	function automatic void decode_byte(input logic [7:0] data);
		logic [CODE_W-1:0] mask;
		int hit;
		int first;
		decoded_t r;
		first = awaited_symbols.size();
		for (int b = BYTE_BITS - 1; b >= 0; b--) begin
			if (decoded >= target)
				break;
			acc = {acc[CODE_W-2:0], data[b]};
			acc_len++;
			mask = ~({CODE_W{1'b1}} << acc_len);
			hit = -1;
			for (int i = 0; i < TABLE_SLOTS; i++) begin
				if (hit < 0 && slot_len[i] != '0 && slot_len[i] == acc_len &&
				    ((slot_code[i] ^ acc) & mask) == '0)
					hit = i;
			end
			if (hit >= 0) begin
				decoded++;
				r.symbol = slot_sym[hit];
				r.no_match = 1'b0;
				r.stream_done = (decoded == target);
				r.last_of_run = 1'b0;
				awaited_symbols = {awaited_symbols, r};
				acc = '0;
				acc_len = 0;
			end else if (acc_len >= MAX_CODE_BITS) begin
				r = '0;
				r.no_match = 1'b1;
				awaited_symbols = {awaited_symbols, r};
				acc = '0;
				acc_len = 0;
			end
		end
		if (awaited_symbols.size() > first)
			awaited_symbols[awaited_symbols.size() - 1].last_of_run = 1'b1;
	endfunction

	function automatic void note_mismatch(input string field, input logic [31:0] want,
	                                      input logic [31:0] got);
		mismatches++;
		if (mismatches <= REPORT_LIMIT)
			$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		decoded_t want;
		if (!arst_n) begin
			for (int i = 0; i < TABLE_SLOTS; i++) begin
				slot_sym[i] = '0;
				slot_len[i] = '0;
				slot_code[i] = '0;
			end
			acc = '0;
			acc_len = 0;
			decoded = '0;
			target = '0;
			awaited_symbols.delete();
			outstanding = 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (no_match)
					misses_checked++;
				else
					symbols_checked++;
				if (awaited_symbols.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$error("result with nothing awaited: symbol 0x%0h no_match %0b",
						       symbol, no_match);
				end else begin
					want = awaited_symbols.pop_front();
					if (symbol !== want.symbol)
						note_mismatch("symbol", want.symbol, symbol);
					if (no_match !== want.no_match)
						note_mismatch("no_match", want.no_match, no_match);
					if (stream_done !== want.stream_done)
						note_mismatch("stream_done", want.stream_done, stream_done);
					if (last_of_run !== want.last_of_run)
						note_mismatch("last_of_run", want.last_of_run, last_of_run);
				end
			end
			if (cfg_we)
				target = cfg_wdata;
			if (item_valid && !item_stall) begin
				case (func)
					FUNC_LOAD: begin
						slot_sym[entry_index] = entry_symbol;
						slot_len[entry_index] = entry_length;
						slot_code[entry_index] = entry_code;
					end
					FUNC_DATA: decode_byte(data_byte);
					FUNC_RESTART: begin
						acc = '0;
						acc_len = 0;
						decoded = '0;
					end
					default: ;
				endcase
			end
			outstanding = awaited_symbols.size();
		end
	end
endmodule

>>> tb/tb_top.sv
// Testbench top for the prefix code table decoder: stimulus, handshake timing and verdict.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import pcd_pkg::*;

	// The one func code that the block is meant to ignore.
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	// This covers a data byte still at work when the last result has already been
	// taken, with room to spare.
	localparam int SETTLE_CYCLES = 64;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int ITEM_TARGET   = 500;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [COUNT_W-1:0]    cfg_wdata;
	logic                  item_valid;
	logic                  item_stall;
	logic [FUNC_W-1:0]     func;
	logic [7:0]            entry_index;
	logic [7:0]            entry_symbol;
	logic [5:0]            entry_length;
	logic [31:0]           entry_code;
	logic [7:0]            data_byte;
	logic                  result_valid;
	logic                  result_stall;
	logic [7:0]            symbol;
	logic                  no_match;
	logic                  stream_done;
	logic                  last_of_run;

	int mismatches;
	int outstanding;
	int symbols_checked;
	int misses_checked;
	int items_sent;
	int phases_run;

	// When clear, both sides run flat out; each random phase decides this afresh so that
	// stretches without any idling appear between the stretches with random gaps.
	bit idling = 1'b1;

	// Stimulus-side view of the current code table, used to load and clear the table and to build streams.
	logic [31:0]     leaf_code[$];
	int              leaf_len[$];
	int              live_leaf[$];
	logic [7:0]      used_slots[$];
	bit              slot_taken[TABLE_SLOTS];
	bit              stream_bits[$];

	prefix_code_table_decoder_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.func         (func),
		.entry_index  (entry_index),
		.entry_symbol (entry_symbol),
		.entry_length (entry_length),
		.entry_code   (entry_code),
		.data_byte    (data_byte),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.symbol       (symbol),
		.no_match     (no_match),
		.stream_done  (stream_done),
		.last_of_run  (last_of_run)
	);

	pcd_decode_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.item_valid      (item_valid),
		.item_stall      (item_stall),
		.func            (func),
		.entry_index     (entry_index),
		.entry_symbol    (entry_symbol),
		.entry_length    (entry_length),
		.entry_code      (entry_code),
		.data_byte       (data_byte),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.symbol          (symbol),
		.no_match        (no_match),
		.stream_done     (stream_done),
		.last_of_run     (last_of_run),
		.mismatches      (mismatches),
		.outstanding     (outstanding),
		.symbols_checked (symbols_checked),
		.misses_checked  (misses_checked)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Overall limit on the run. The slowest legal run, with every gap and every stall at
	// its longest, stays well below a fifth of this.
	initial begin
		#12_000_000;
		$display("tb_top: done, errors");
		$finish;
	end

	// Result side. Before each result transaction a stall of random length is drawn and
	// applied at once, whether or not a result is on offer yet, so that the hold-off lands
	// on every phase of the decoder's work, including while it fills its second result.
	initial begin
		int hold;
		result_stall = 1'b0;
		@(negedge clk);
		forever begin
			hold = idling ? $urandom_range(0, 14) : 0;
			if (hold > 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			result_stall <= 1'b0;
			do
				@(posedge clk);
			while (result_valid !== 1'b1);
			@(negedge clk);
		end
	end

	// Offers one input transaction after a random gap and holds it until it is taken. It
	// returns at the falling edge after acceptance with valid still high, so a following
	// call in the same step can present the next transaction back to back. Anything that
	// lets time pass between calls must lower valid first.
	task automatic send_item(input logic [FUNC_W-1:0] f, input logic [7:0] idx,
	                         input logic [7:0] sym, input logic [5:0] len,
	                         input logic [31:0] code, input logic [7:0] data);
		int gap;
		gap = idling ? $urandom_range(0, 14) : 0;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		func <= f;
		entry_index <= idx;
		entry_symbol <= sym;
		entry_length <= len;
		entry_code <= code;
		data_byte <= data;
		item_valid <= 1'b1;
		do
			@(posedge clk);
		while (item_stall !== 1'b0);
		@(negedge clk);
		if (f != FUNC_UNUSED)
			items_sent++;
	endtask

	// Fields that a transaction does not use are filled with random values throughout.
	task automatic load_slot(input logic [7:0] idx, input logic [7:0] sym,
	                         input logic [5:0] len, input logic [31:0] code);
		send_item(FUNC_LOAD, idx, sym, len, code, 8'($urandom));
	endtask

	task automatic feed_byte(input logic [7:0] data);
		send_item(FUNC_DATA, 8'($urandom), 8'($urandom), 6'($urandom), $urandom, data);
	endtask

	task automatic restart_stream();
		send_item(FUNC_RESTART, 8'($urandom), 8'($urandom), 6'($urandom), $urandom,
		          8'($urandom));
	endtask

	// The register may only change while the block is idle, so this waits until every
	// predicted result has been taken and then lets a byte that yields nothing run out.
	task automatic write_count(input logic [COUNT_W-1:0] value);
		item_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_wdata <= value;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Sends every whole byte gathered so far, first stream bit in the MSB.
	task automatic feed_whole_bytes();
		logic [7:0] packed_bits;
		while (stream_bits.size() >= BYTE_BITS) begin
			for (int b = BYTE_BITS - 1; b >= 0; b--)
				packed_bits[b] = stream_bits.pop_front();
			feed_byte(packed_bits);
		end
	endtask

	// Builds a fresh prefix code by splitting leaves of a binary tree, so the full code is
	// complete and every bit sequence decodes. In chain mode the newest leaf is always
	// split, which gives a code of every length up to the maximum. With holes, some
	// leaves are left out of the table so that a stream can run into a no-match. The old
	// table is cleared first, and odd entries may be added: an overlong length that
	// can never match, and a second slot with the same code as a live one.
	task automatic load_prefix_table(input int leaves, input bit chain, input bit holes);
		int pick;
		int slot;
		logic [31:0] c;
		foreach (used_slots[k])
			load_slot(used_slots[k], 8'($urandom), '0, $urandom);
		used_slots.delete();
		foreach (slot_taken[k])
			slot_taken[k] = 1'b0;
		leaf_code = '{32'd0, 32'd1};
		leaf_len = '{1, 1};
		live_leaf.delete();
		while (leaf_code.size() < leaves) begin
			if (chain || $urandom_range(0, 3) == 0)
				pick = leaf_code.size() - 1;
			else
				pick = $urandom_range(0, leaf_code.size() - 1);
			if (leaf_len[pick] >= MAX_CODE_BITS)
				break;
			c = leaf_code[pick];
			leaf_code[pick] = c << 1;
			leaf_len[pick] = leaf_len[pick] + 1;
			leaf_code = {leaf_code, (c << 1) | 32'd1};
			leaf_len = {leaf_len, leaf_len[pick]};
		end
		foreach (leaf_code[k]) begin
			if (k > 0 && holes && $urandom_range(0, 4) == 0)
				continue;
			do
				slot = $urandom_range(0, TABLE_SLOTS - 1);
			while (slot_taken[slot]);
			slot_taken[slot] = 1'b1;
			used_slots = {used_slots, 8'(slot)};
			live_leaf = {live_leaf, k};
			// Bits above the code length are junk and must not take part in the compare.
			load_slot(8'(slot), 8'($urandom), 6'(leaf_len[k]),
			          leaf_code[k] | ($urandom << leaf_len[k]));
		end
		if ($urandom_range(0, 1) == 0) begin
			do
				slot = $urandom_range(0, TABLE_SLOTS - 1);
			while (slot_taken[slot]);
			slot_taken[slot] = 1'b1;
			used_slots = {used_slots, 8'(slot)};
			load_slot(8'(slot), 8'($urandom), 6'($urandom_range(MAX_CODE_BITS + 1, 63)),
			          $urandom);
		end
		if ($urandom_range(0, 1) == 0) begin
			pick = live_leaf[$urandom_range(0, live_leaf.size() - 1)];
			do
				slot = $urandom_range(0, TABLE_SLOTS - 1);
			while (slot_taken[slot]);
			slot_taken[slot] = 1'b1;
			used_slots = {used_slots, 8'(slot)};
			load_slot(8'(slot), 8'($urandom), 6'(leaf_len[pick]), leaf_code[pick]);
		end
	endtask

	// Encodes a run of random symbols from the live part of the table. Now and then the
	// run is broken: stray bits, an ignored func code or a restart part way through.
	task automatic send_stream(input int count);
		int k;
		stream_bits.delete();
		for (int n = 0; n < count; n++) begin
			k = live_leaf[$urandom_range(0, live_leaf.size() - 1)];
			for (int b = leaf_len[k] - 1; b >= 0; b--)
				stream_bits = {stream_bits, leaf_code[k][b]};
			case ($urandom_range(0, 24))
				0: repeat ($urandom_range(1, 12)) stream_bits = {stream_bits, 1'($urandom)};
				1: begin
					feed_whole_bytes();
					restart_stream();
				end
				2: send_item(FUNC_UNUSED, 8'($urandom), 8'($urandom), 6'($urandom),
				             $urandom, 8'($urandom));
				default: ;
			endcase
			feed_whole_bytes();
		end
		// Padding after the last symbol, sometimes with a whole spare byte.
		while (stream_bits.size() % BYTE_BITS != 0)
			stream_bits = {stream_bits, 1'($urandom)};
		if ($urandom_range(0, 1) == 0)
			repeat (BYTE_BITS) stream_bits = {stream_bits, 1'($urandom)};
		feed_whole_bytes();
	endtask

	initial begin
		int leaves;
		int count;
		int drain;
		bit chain;
		bit holes;
		logic [COUNT_W-1:0] target;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		item_valid = 1'b0;
		func = FUNC_LOAD;
		entry_index = '0;
		entry_symbol = '0;
		entry_length = '0;
		entry_code = '0;
		data_byte = '0;
		items_sent = 0;
		phases_run = 0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Directed part. Straight after reset the symbol count is zero, so a data byte
		// must be dropped without a result.
		feed_byte(8'h5A);
		write_count('1);

		// A one-bit code "0" with junk above it, a two-bit code "10" held in two slots
		// (the lower slot must win), two overlong slots and a 32-bit code of all ones.
		load_slot(8'd0, 8'hA5, 6'd1, 32'hFFFF_FFFE);
		load_slot(8'd1, 8'h00, 6'd2, 32'h0000_0002);
		load_slot(8'd2, 8'hFF, 6'd2, 32'hFFFF_FFFE);
		load_slot(8'd3, 8'h3C, 6'd33, 32'hFFFF_FFFF);
		load_slot(8'hFE, 8'h77, 6'd63, 32'hFFFF_FFFF);
		load_slot(8'hFF, 8'h81, 6'd32, 32'hFFFF_FFFF);
		send_item(FUNC_UNUSED, 8'h00, 8'h00, 6'd1, 32'h0, 8'h00);

		// Eight symbols from one byte, then four, then the longest code across four bytes.
		feed_byte(8'h00);
		feed_byte(8'hAA);
		repeat (4) feed_byte(8'hFF);

		// With the long code gone, 32 ones can only end in a no-match.
		load_slot(8'hFF, 8'h81, 6'd0, 32'hFFFF_FFFF);
		repeat (4) feed_byte(8'hFF);

		// A restart must throw away a partly gathered code.
		feed_byte(8'hFF);
		restart_stream();
		feed_byte(8'h00);

		// A short stream: the third symbol completes it and the rest of the byte is padding.
		write_count(32'd3);
		restart_stream();
		feed_byte(8'h00);
		feed_byte(8'h00);

		// Lowering the count below what has already been decoded stops decoding as well.
		write_count(32'd1);
		feed_byte(8'h2A);

		// Random part: each phase sets a count, loads a new table and sends a stream.
		while (items_sent < ITEM_TARGET) begin
			idling = ($urandom_range(0, 3) != 0);
			chain = (phases_run == 1) || ($urandom_range(0, 7) == 0);
			holes = ($urandom_range(0, 2) == 0);
			leaves = chain ? MAX_CODE_BITS + 1 : $urandom_range(2, 20);
			count = $urandom_range(4, 40);
			case ($urandom_range(0, 5))
				0: target = '1;
				1, 2: target = count;
				3: target = count - $urandom_range(1, 3);
				4: target = count + $urandom_range(1, 4);
				default: target = $urandom_range(0, 2);
			endcase
			write_count(target);
			load_prefix_table(leaves, chain, holes);
			restart_stream();
			send_stream(count);
			phases_run++;
		end

		// Let the last results drain, then allow for a byte still being worked on.
		item_valid <= 1'b0;
		drain = 0;
		while (outstanding != 0 && drain < DRAIN_LIMIT) begin
			@(negedge clk);
			drain++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (outstanding != 0)
			$error("%0d predicted results never arrived", outstanding);

		$display("tb_top: %0d input transactions over %0d random code tables",
		         items_sent, phases_run);
		$display("tb_top: %0d decoded symbols and %0d no-match results compared",
		         symbols_checked, misses_checked);
		if (mismatches == 0 && outstanding == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end
endmodule
